// ----- src/encoder_speed_observer_macros.svh -----
// ----------------------------------------------------------------------------
// Encoder speed observer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_OBSERVER_MACROS_SVH
`define ENCODER_SPEED_OBSERVER_MACROS_SVH

// condition holds at every clock edge
`define ESO_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define ESO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/esobs_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder speed observer package
// Payload types, unit request/response types, constants and saturation helper.
// ----------------------------------------------------------------------------
package esobs_pkg;

    // input transaction
    typedef struct packed {
        logic        kind;
        logic [11:0] encoder_raw;
        logic [31:0] tick;
    } t_in;

    // output transaction
    typedef struct packed {
        logic signed [31:0] angle_counts;
        logic signed [47:0] speed_deg_q16;
        logic signed [47:0] speed_rad_q16;
        logic signed [47:0] speed_counts_q16;
    } t_out;

    // shared unit operations
    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    localparam int PROD_W    = 72;
    localparam int DVD_W     = 64;
    localparam int DSR_W     = 32;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 6;

    // encoder resolution, a power of two so scaling is a shift
    localparam int COUNTS_PER_TURN = 4096;
    localparam int CPT_SHIFT       = $clog2(COUNTS_PER_TURN);

    typedef struct packed {
        logic               start;
        t_op                op;
        logic [DVD_W-1:0]   a;   // multiplicand or dividend
        logic [DSR_W-1:0]   b;   // multiplier or divisor
    } t_unit_req;

    typedef struct packed {
        logic               done;
        logic [PROD_W-1:0]  q;   // product or quotient
        logic [DSR_W-1:0]   r;   // remainder
    } t_unit_rsp;

    // config register indexes
    localparam logic CFG_LPF_ALPHA    = 1'b0;
    localparam logic CFG_LOOP_RATE_HZ = 1'b1;

    localparam logic [16:0] ALPHA_RESET = 17'd6554;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic [19:0] RATE_RESET  = 20'd10000;
    localparam logic [8:0]  DEG_TURN    = 9'd360;
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [PROD_W-1:0] MAG47 = PROD_W'(1) << 47;

    // apply sign to a magnitude and saturate to 48 bits
    function automatic logic signed [47:0] signed_sat(input logic neg,
                                                      input logic [PROD_W-1:0] mag);
        logic [PROD_W-1:0] m;
        m = (mag > MAG47) ? MAG47 : mag;
        if (neg) begin
            signed_sat = 48'(-m);
        end else begin
            signed_sat = (m > MAG47 - PROD_W'(1)) ? 48'(MAG47 - PROD_W'(1)) : 48'(m);
        end
    endfunction

endpackage

// ----- src/esobs_unit.sv -----
// ----------------------------------------------------------------------------
// Shared serial arithmetic unit
// Shift-add multiplier (one multiplier bit per cycle) and restoring divider
// (one quotient bit per cycle) behind a single start/done handshake.
// ----------------------------------------------------------------------------
module esobs_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  esobs_pkg::t_unit_req  i_req,
    output esobs_pkg::t_unit_rsp  o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [esobs_pkg::CNT_W-1:0]         r_cnt;
    esobs_pkg::t_op                      r_op;
    logic [esobs_pkg::PROD_W-1:0]        r_acc;
    logic [esobs_pkg::PROD_W-1:0]        r_mcand;
    logic [esobs_pkg::DSR_W-1:0]         r_mplier;
    logic [esobs_pkg::DVD_W-1:0]         r_dvd;
    logic [esobs_pkg::DSR_W-1:0]         r_dsr;
    logic [esobs_pkg::DSR_W:0]           r_rem;

    logic [esobs_pkg::DSR_W:0]           trial;
    logic                                fits;

    // divider trial step
    assign trial = {r_rem[esobs_pkg::DSR_W-1:0], r_dvd[esobs_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == esobs_pkg::OP_MUL) ?
                          esobs_pkg::CNT_W'(esobs_pkg::MUL_STEPS - 1) :
                          esobs_pkg::CNT_W'(esobs_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op     <= i_req.op;
            r_acc    <= '0;
            r_mcand  <= esobs_pkg::PROD_W'(i_req.a);
            r_mplier <= i_req.b;
            r_dvd    <= i_req.a;
            r_dsr    <= i_req.b;
            r_rem    <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                esobs_pkg::OP_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
                esobs_pkg::OP_DIV: begin
                    r_rem <= fits ? (trial - {1'b0, r_dsr}) : trial;
                    r_acc <= {r_acc[esobs_pkg::PROD_W-2:0], fits};
                    r_dvd <= r_dvd << 1;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_acc;
    assign o_rsp.r    = r_rem[esobs_pkg::DSR_W-1:0];

endmodule

// ----- src/encoder_speed_observer.sv -----
// ----------------------------------------------------------------------------
// Encoder speed observer
// Multi-turn unwrap, moving-average position and filtered speed estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries kind, encoder_raw, tick.
//   Output channel (o_out_valid / i_out_ready) returns one transaction per
//   input: multi-turn angle plus filtered speed in counts, deg and rad per s.
//   Config port: i_cfg_we with i_cfg_idx 0 = lpf_alpha, 1 = loop_rate_hz.
//   One item at a time, all multiplies and divides in one shared serial unit:
//   a reset item takes two scale multiplies; a full speed update takes two
//   divides and two multiplies more than an update with a zero raw speed.
//   The next item can be taken in the cycle after the result is loaded;
//   if the receiver stalls, the result waits there and a following
//   finished result waits in the last sequencer step until the register
//   frees up.
//   Reset clears position, windows and filter state; the rings need no
//   clearing pass, their entries are read only after being written.
// ----------------------------------------------------------------------------
`include "encoder_speed_observer_macros.svh"

module encoder_speed_observer #(
    parameter int AVG_WINDOW      = 8,
    parameter int HIST_WINDOW     = 8,
    parameter int DIFF_SPAN       = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  esobs_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output esobs_pkg::t_out  o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [19:0]      i_cfg_data
);

    localparam int AIW  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int AFW  = $clog2(AVG_WINDOW + 1);
    localparam int HIW  = $clog2(HIST_WINDOW);
    localparam int HFW  = $clog2(HIST_WINDOW + 1);
    localparam int SUMW = 32 + AFW;
    localparam int DSM  = DIFF_SPAN % HIST_WINDOW;
    localparam int HALF = esobs_pkg::COUNTS_PER_TURN / 2;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SUM  = 14'b00000000000010,
        S_AVG  = 14'b00000000000100,
        S_CHK  = 14'b00000000001000,
        S_QDIV = 14'b00000000010000,
        S_RMUL = 14'b00000000100000,
        S_RDIV = 14'b00000001000000,
        S_QMUL = 14'b00000010000000,
        S_DIFF = 14'b00000100000000,
        S_FILT = 14'b00001000000000,
        S_EMIT = 14'b00010000000000,
        S_DEG  = 14'b00100000000000,
        S_RAD  = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    logic   r_issued;

    // configuration
    logic [16:0] r_alpha;
    logic [19:0] r_rate;

    // observer state
    logic [11:0]        r_prev;
    logic [31:0]        r_pos;
    logic [AIW-1:0]     r_avg_slot;
    logic [AFW-1:0]     r_avg_fill;
    logic [HIW-1:0]     r_hist_slot;
    logic [HFW-1:0]     r_hist_fill;
    logic               r_primed;
    logic signed [47:0] r_s;

    // rings
    logic [31:0] r_avg_mem  [AVG_WINDOW];
    logic [47:0] r_hang_mem [HIST_WINDOW];
    logic [31:0] r_htk_mem  [HIST_WINDOW];
    logic [31:0] r_avg_rd;
    logic [47:0] r_hang_rd;
    logic [31:0] r_htk_rd;

    // work registers
    logic [31:0]             r_tick;
    logic [AFW-1:0]          r_idx;
    logic                    r_rd_vld;
    logic signed [SUMW-1:0]  r_sum;
    logic signed [47:0]      r_newest;
    logic                    r_neg;
    logic [48:0]             r_mag;
    logic [31:0]             r_gap;
    logic [63:0]             r_q;
    logic [31:0]             r_r;
    logic [63:0]             r_prod;
    logic [19:0]             r_rr;
    logic signed [47:0]      r_raw;
    logic signed [47:0]      r_deg;
    logic signed [47:0]      r_rad;
    logic                    r_out_valid;
    esobs_pkg::t_out         r_out;

    esobs_pkg::t_unit_req    u_req;
    esobs_pkg::t_unit_rsp    u_rsp;

    logic                    in_acc;
    logic                    out_load;
    logic signed [17:0]      step_raw;
    logic signed [17:0]      step;
    logic [31:0]             pos_new;
    logic                    avg_rd_en;
    logic [HIW:0]            old_ext;
    logic [HIW-1:0]          old_addr;
    logic signed [48:0]      ang_diff;
    logic [31:0]             gap;
    logic signed [48:0]      flt_diff;
    logic [16:0]             alpha_eff;
    logic [SUMW-1:0]         sum_mag;
    logic [esobs_pkg::PROD_W-1:0] raw_total;
    logic [48:0]             flt_step;
    logic [AIW-1:0]          avg_slot_nx;
    logic [AFW-1:0]          avg_fill_nx;
    logic [HIW-1:0]          hist_slot_nx;
    logic [HFW-1:0]          hist_fill_nx;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // half-turn unwrap of the reading step
    assign step_raw = 18'($signed({1'b0, i_in_data.encoder_raw})) -
                      18'($signed({1'b0, r_prev}));
    always_comb begin
        if (step_raw > 18'(HALF)) begin
            step = step_raw - 18'(esobs_pkg::COUNTS_PER_TURN);
        end else if (step_raw < -18'(HALF)) begin
            step = step_raw + 18'(esobs_pkg::COUNTS_PER_TURN);
        end else begin
            step = step_raw;
        end
    end
    assign pos_new = r_pos + 32'(step);

    // ring pointer advance
    assign avg_slot_nx  = (32'(r_avg_slot) == 32'(AVG_WINDOW - 1)) ? '0 : r_avg_slot + 1'b1;
    assign avg_fill_nx  = (32'(r_avg_fill) == 32'(AVG_WINDOW)) ? r_avg_fill
                                                               : r_avg_fill + 1'b1;
    assign hist_slot_nx = (32'(r_hist_slot) == 32'(HIST_WINDOW - 1)) ? '0
                                                                     : r_hist_slot + 1'b1;
    assign hist_fill_nx = (32'(r_hist_fill) == 32'(HIST_WINDOW)) ? r_hist_fill
                                                                 : r_hist_fill + 1'b1;

    // entry DIFF_SPAN older than the slot about to be written
    assign old_ext  = ({1'b0, r_hist_slot} >= (HIW+1)'(DSM)) ?
                      ({1'b0, r_hist_slot} - (HIW+1)'(DSM)) :
                      ({1'b0, r_hist_slot} + (HIW+1)'(HIST_WINDOW - DSM));
    assign old_addr = old_ext[HIW-1:0];

    assign avg_rd_en = (r_state == S_SUM) && (r_idx < r_avg_fill);
    assign ang_diff  = 49'(r_newest) - 49'($signed(r_hang_rd));
    assign gap       = r_tick - r_htk_rd;
    assign flt_diff  = 49'(r_raw) - 49'(r_s);
    assign alpha_eff = (r_alpha > esobs_pkg::ALPHA_ONE) ? esobs_pkg::ALPHA_ONE : r_alpha;
    assign sum_mag   = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign raw_total = u_rsp.q + esobs_pkg::PROD_W'(r_rr);
    assign flt_step  = u_rsp.q[64:16];

    // avg ring
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_avg_mem[i_in_data.kind ? r_avg_slot : AIW'(0)] <=
                i_in_data.kind ? pos_new : 32'(i_in_data.encoder_raw);
        end
        if (avg_rd_en) begin
            r_avg_rd <= r_avg_mem[r_idx[AIW-1:0]];
        end
    end

    // history ring
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in_data.kind) begin
            r_hang_mem[HIW'(0)] <= {4'd0, i_in_data.encoder_raw, 32'd0} >> 16;
            r_htk_mem[HIW'(0)]  <= i_in_data.tick;
        end else if (r_state == S_AVG && u_rsp.done) begin
            r_hang_mem[r_hist_slot] <= r_sum[SUMW-1] ? -u_rsp.q[47:0] : u_rsp.q[47:0];
            r_htk_mem[r_hist_slot]  <= r_tick;
        end
        if (in_acc) begin
            r_hang_rd <= r_hang_mem[old_addr];
            r_htk_rd  <= r_htk_mem[old_addr];
        end
    end

    // shared unit request
    always_comb begin
        u_req       = '0;
        u_req.start = !r_issued;
        unique case (r_state)
            S_AVG: begin
                u_req.op = esobs_pkg::OP_DIV;
                u_req.a  = 64'(sum_mag) << 16;
                u_req.b  = 32'(r_avg_fill);
            end
            S_QDIV: begin
                u_req.op = esobs_pkg::OP_DIV;
                u_req.a  = 64'(r_mag);
                u_req.b  = r_gap;
            end
            S_RMUL: begin
                u_req.op = esobs_pkg::OP_MUL;
                u_req.a  = 64'(r_r);
                u_req.b  = 32'(r_rate);
            end
            S_RDIV: begin
                u_req.op = esobs_pkg::OP_DIV;
                u_req.a  = r_prod;
                u_req.b  = r_gap;
            end
            S_QMUL: begin
                u_req.op = esobs_pkg::OP_MUL;
                u_req.a  = r_q;
                u_req.b  = 32'(r_rate);
            end
            S_FILT: begin
                u_req.op = esobs_pkg::OP_MUL;
                u_req.a  = 64'(r_mag);
                u_req.b  = 32'(alpha_eff);
            end
            // unit scale products; the divide by counts per turn is a shift
            S_DEG: begin
                u_req.op = esobs_pkg::OP_MUL;
                u_req.a  = 64'(r_mag);
                u_req.b  = 32'(esobs_pkg::DEG_TURN);
            end
            S_RAD: begin
                u_req.op = esobs_pkg::OP_MUL;
                u_req.a  = 64'(r_mag);
                u_req.b  = 32'(esobs_pkg::TWO_PI_Q16);
            end
            S_IDLE, S_SUM, S_CHK, S_DIFF, S_EMIT, S_OUT: begin
                u_req.start = 1'b0;
            end
            default: begin
                u_req.start = 1'b0;
            end
        endcase
    end

    esobs_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= esobs_pkg::ALPHA_RESET;
            r_rate  <= esobs_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                esobs_pkg::CFG_LPF_ALPHA:    r_alpha <= i_cfg_data[16:0];
                esobs_pkg::CFG_LOOP_RATE_HZ: r_rate  <= i_cfg_data;
                default:                     r_rate  <= r_rate;
            endcase
        end
    end

    // sequencer and observer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_prev      <= '0;
            r_pos       <= '0;
            r_avg_slot  <= '0;
            r_avg_fill  <= '0;
            r_hist_slot <= '0;
            r_hist_fill <= '0;
            r_primed    <= 1'b0;
            r_s         <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (u_req.start) begin
                r_issued <= 1'b1;
            end
            if (u_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tick <= i_in_data.tick;
                        r_prev <= i_in_data.encoder_raw;
                        if (!i_in_data.kind) begin
                            r_pos       <= 32'(i_in_data.encoder_raw);
                            r_avg_slot  <= (AVG_WINDOW > 1) ? AIW'(1) : AIW'(0);
                            r_avg_fill  <= AFW'(1);
                            r_hist_slot <= HIW'(1);
                            r_hist_fill <= HFW'(1);
                            r_primed    <= 1'b0;
                            r_state     <= S_EMIT;
                        end else begin
                            r_pos      <= pos_new;
                            r_avg_slot <= avg_slot_nx;
                            r_avg_fill <= avg_fill_nx;
                            r_idx      <= '0;
                            r_rd_vld   <= 1'b0;
                            r_sum      <= '0;
                            r_state    <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_rd_vld <= avg_rd_en;
                    if (avg_rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUMW'($signed(r_avg_rd));
                    end
                    if (!avg_rd_en && !r_rd_vld) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (u_rsp.done) begin
                        r_newest    <= r_sum[SUMW-1] ? -u_rsp.q[47:0] : u_rsp.q[47:0];
                        r_hist_slot <= hist_slot_nx;
                        r_hist_fill <= hist_fill_nx;
                        r_state     <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_neg <= ang_diff < 0;
                    r_mag <= ang_diff < 0 ? 49'(-ang_diff) : 49'(ang_diff);
                    r_gap <= gap;
                    if (!r_primed) begin
                        r_primed <= 1'b1;
                        r_s      <= '0;
                        r_state  <= S_EMIT;
                    end else if (32'(r_hist_fill) <= 32'(DIFF_SPAN) || gap == '0 ||
                                 r_rate == '0) begin
                        r_raw   <= '0;
                        r_state <= S_DIFF;
                    end else begin
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (u_rsp.done) begin
                        r_q     <= u_rsp.q[63:0];
                        r_r     <= u_rsp.r;
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    if (u_rsp.done) begin
                        r_prod  <= u_rsp.q[63:0];
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (u_rsp.done) begin
                        r_rr    <= u_rsp.q[19:0];
                        r_state <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    if (u_rsp.done) begin
                        r_raw   <= esobs_pkg::signed_sat(r_neg, raw_total);
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg   <= flt_diff < 0;
                    r_mag   <= flt_diff < 0 ? 49'(-flt_diff) : 49'(flt_diff);
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    if (u_rsp.done) begin
                        r_s     <= r_neg ? r_s - 48'(flt_step) : r_s + 48'(flt_step);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_neg   <= r_s < 0;
                    r_mag   <= r_s < 0 ? 49'(-49'(r_s)) : 49'(r_s);
                    r_state <= S_DEG;
                end
                S_DEG: begin
                    if (u_rsp.done) begin
                        r_deg   <= esobs_pkg::signed_sat(r_neg,
                                       u_rsp.q >> esobs_pkg::CPT_SHIFT);
                        r_state <= S_RAD;
                    end
                end
                S_RAD: begin
                    // Q16 scale drop and counts-per-turn shift in one
                    if (u_rsp.done) begin
                        r_rad   <= esobs_pkg::signed_sat(r_neg,
                                       u_rsp.q >> (16 + esobs_pkg::CPT_SHIFT));
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.angle_counts     <= r_pos;
            r_out.speed_deg_q16    <= r_deg;
            r_out.speed_rad_q16    <= r_rad;
            r_out.speed_counts_q16 <= r_s;
        end
    end

    // checks
    `ESO_ASSERT_HOLDS(a_avg_fill_cap, 32'(r_avg_fill) <= 32'(AVG_WINDOW), "avg fill overrun")
    `ESO_ASSERT_HOLDS(a_unit_quiet, (r_state != S_IDLE) || !r_issued, "unit busy in idle")
    `ESO_ASSERT_NEXT(a_busy_after_acc, in_acc, !o_in_ready, "accepted while busy")
    `ESO_ASSERT_NEXT(a_out_loaded, out_load, r_out_valid && (r_state == S_IDLE), "result lost")

endmodule
